### rtl/isr_pkg.sv
// shared constants and types for the integer square root block
package isr_pkg;

   localparam int INPUT_BITS = 31;
   localparam int ROOT_W     = (INPUT_BITS + 1) / 2;
   localparam int PAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 1;
   localparam int DIFF_W     = REM_W + 3;
   localparam int STEP_W     = $clog2(ROOT_W + 1);
   localparam int OUT_W      = 16;
   localparam int SAT_W      = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;

   typedef struct packed {
      logic load;
      logic shift;
   } isr_ctl_type;

endpackage

### rtl/isr_cell.sv
// one cell of the chain: a radicand bit pair and one root bit
module isr_cell
   import isr_pkg::*;
(
   input  logic        clock,
   input  isr_ctl_type ctl,
   input  logic [1:0]  load_pair,
   input  logic [1:0]  next_pair,
   input  logic        next_bit,
   output logic [1:0]  pair,
   output logic        root_bit
);

   logic [1:0] pair_ff;
   logic [1:0] pair_in;
   logic       bit_ff;
   logic       bit_in;

   always_comb begin
      pair_in = pair_ff;
      bit_in  = bit_ff;
      if (ctl.load) begin
         pair_in = load_pair;
         bit_in  = 1'b0;
      end else if (ctl.shift) begin
         pair_in = next_pair;
         bit_in  = next_bit;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      bit_ff  <= bit_in;
   end

   assign pair     = pair_ff;
   assign root_bit = bit_ff;

endmodule

### rtl/isr_step.sv
// restoring trial subtract and partial remainder register
module isr_step
   import isr_pkg::*;
(
   input  logic              clock,
   input  isr_ctl_type       ctl,
   input  logic [1:0]        pair,
   input  logic [ROOT_W-1:0] root,
   output logic              new_bit
);

   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  rem_in;
   logic [DIFF_W-1:0] shifted;
   logic [DIFF_W-1:0] trial;
   logic [DIFF_W-1:0] diff;

   always_comb begin
      shifted = DIFF_W'({rem_ff, pair});
      trial   = DIFF_W'({root, 2'b01});
      diff    = shifted - trial;
      new_bit = ~diff[DIFF_W-1];
      rem_in  = rem_ff;
      if (ctl.load) begin
         rem_in = '0;
      end else if (ctl.shift) begin
         rem_in = new_bit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

endmodule

### rtl/integer_square_root.sv
// integer square root: floor of sqrt of the radicand, one root bit per cycle
// a beat taken while idle starts a run of one step per root bit; rsp_valid is registered with the last root bit
// a new beat is taken only while idle, once the previous run is through; busy is high during the steps
// the step count is set by the root width, (INPUT_BITS+1)/2 cells in the chain
// the result beat holds for one cycle; the receiver cannot stall
// synchronous active-high reset clears busy and the result strobe
module integer_square_root
   import isr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [INPUT_BITS-1:0] req_radicand,
   output logic                  rsp_valid,
   output logic [OUT_W-1:0]      rsp_root
);

   typedef enum logic {IDLE, RUN} state_type;

   localparam logic [STEP_W-1:0] LastStep = STEP_W'(ROOT_W - 1);

   state_type        state_ff;
   logic [STEP_W-1:0] count_ff;
   logic             rsp_valid_ff;
   isr_ctl_type      ctl;
   logic             accept;
   logic [PAD_W-1:0] padded;
   logic [1:0]       pairs [ROOT_W];
   logic [ROOT_W-1:0] root;
   logic             new_bit;
   logic [SAT_W-1:0] root_wide;

   assign accept    = start && (state_ff == IDLE);
   assign ctl.load  = accept;
   assign ctl.shift = (state_ff == RUN);
   assign padded    = PAD_W'(req_radicand);

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      logic [1:0] next_pair;
      logic       next_bit;
      if (i == ROOT_W - 1) begin : g_tail
         assign next_pair = 2'b00;
         assign next_bit  = new_bit;
      end else begin : g_body
         assign next_pair = pairs[i+1];
         assign next_bit  = root[ROOT_W-2-i];
      end
      isr_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_pair (padded[PAD_W-1-2*i -: 2]),
         .next_pair (next_pair),
         .next_bit  (next_bit),
         .pair      (pairs[i]),
         .root_bit  (root[ROOT_W-1-i])
      );
   end

   isr_step u_step (
      .clock   (clock),
      .ctl     (ctl),
      .pair    (pairs[0]),
      .root    (root),
      .new_bit (new_bit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= RUN;
                  count_ff <= '0;
               end
            end
            RUN: begin
               if (count_ff == LastStep) begin
                  state_ff     <= IDLE;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // saturate when the root is wider than the result port
   assign root_wide = SAT_W'(root);
   assign rsp_root  = (root_wide > SAT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                         : root_wide[OUT_W-1:0];
   assign busy      = (state_ff == RUN);
   assign rsp_valid = rsp_valid_ff;

   a_valid_after_run : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result beat without a finished run");

   a_start_runs : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && count_ff == '0)
      else $error("accepted beat did not start a run");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      busy |-> count_ff <= LastStep)
      else $error("step count out of range");

   a_run_ends : assert property (@(posedge clock) disable iff (reset)
      busy && count_ff == LastStep |=> rsp_valid)
      else $error("last step gave no result beat");

endmodule

### test/integer_square_root_tb.sv
// self-checking testbench for the integer square root block
module integer_square_root_tb
   import isr_pkg::*;
;

   class root_scoreboard;
      logic [OUT_W-1:0] expected_roots[$];
      int unsigned      compared;
      int unsigned      problems;
      int unsigned      largest;

      function logic [OUT_W-1:0] floor_sqrt(logic [INPUT_BITS-1:0] radicand);
         longint unsigned rest;
         longint unsigned acc;
         longint unsigned probe;
         rest  = 64'(radicand);
         acc   = 0;
         probe = 64'd1 << 62;
         while (probe > rest) probe = probe >> 2;
         while (probe != 0) begin
            if (rest >= acc + probe) begin
               rest = rest - (acc + probe);
               acc  = (acc >> 1) + probe;
            end else begin
               acc = acc >> 1;
            end
            probe = probe >> 2;
         end
         if (acc > 64'hFFFF) acc = 64'hFFFF;
         return acc[OUT_W-1:0];
      endfunction

      function void note_radicand(logic [INPUT_BITS-1:0] radicand);
         expected_roots.push_back(floor_sqrt(radicand));
      endfunction

      function void check_root(logic [OUT_W-1:0] root);
         logic [OUT_W-1:0] want;
         if (expected_roots.size() == 0) begin
            problems++;
            if (problems <= 10) $display("unexpected result beat: root %0d", root);
            return;
         end
         want = expected_roots.pop_front();
         compared++;
         if (32'(root) > largest) largest = 32'(root);
         if (root !== want) begin
            problems++;
            if (problems <= 10) $display("root mismatch: expected %0d, actual %0d", want, root);
         end
      endfunction

      function int unsigned pending();
         return expected_roots.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [INPUT_BITS-1:0] req_radicand = '0;
   logic                  rsp_valid;
   logic [OUT_W-1:0]      rsp_root;

   root_scoreboard sb = new();
   int unsigned    sent;
   int unsigned    directed_count;
   int unsigned    failures;

   integer_square_root u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_radicand (req_radicand),
      .rsp_valid    (rsp_valid),
      .rsp_root     (rsp_root)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #4_800_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_root(rsp_root);
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [INPUT_BITS-1:0] random_radicand();
      longint unsigned base;
      longint unsigned k;
      case ($urandom_range(0, 4))
         0: base = 64'($urandom() & 32'h7FFF_FFFF);
         1: begin
            k    = 64'($urandom_range(0, 46340));
            base = k * k;
            case ($urandom_range(0, 2))
               0: if (base != 0) base = base - 1;
               1: base = base + 1;
               default: ;
            endcase
         end
         2: base = 64'(($urandom() & 32'h7FFF_FFFF) >> $urandom_range(0, 30));
         3: base = 64'h7FFF_FFFF - 64'($urandom_range(0, 200000));
         default: base = 64'($urandom_range(0, 1023));
      endcase
      return base[INPUT_BITS-1:0];
   endfunction

   task automatic send_radicand(input logic [INPUT_BITS-1:0] radicand, input int unsigned gap);
      start        <= 1'b1;
      req_radicand <= radicand;
      do @(posedge clock); while (busy);
      sb.note_radicand(radicand);
      sent++;
      if (gap > 0) begin
         start        <= 1'b0;
         req_radicand <= INPUT_BITS'($urandom());
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [INPUT_BITS-1:0] edge_values[$];
      edge_values = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd8, 31'd15, 31'd16, 31'd17,
                      31'd255, 31'd65535, 31'd65536, 31'h4000_0000, 31'h3FFF_FFFF,
                      31'h5555_5555, 31'h2AAA_AAAA, 31'd2147395600, 31'd2147395599,
                      31'd2147395601, 31'd2147302921, 31'd2147302920, 31'h7FFF_FFFF,
                      31'h7FFF_FFFE};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (edge_values[i]) send_radicand(edge_values[i], pick_gap());
      directed_count = edge_values.size();

      repeat (600) send_radicand(random_radicand(), pick_gap());
      start <= 1'b0;
      wait_drained();

      // back to back beats with start held high
      repeat (150) send_radicand(random_radicand(), 0);
      send_radicand(random_radicand(), 1);

      repeat (600) send_radicand(random_radicand(), pick_gap());
      start <= 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);

      failures = sb.problems + sb.pending();
      $display("fed %0d radicands (%0d edge values), compared %0d roots, largest root %0d",
               sent, directed_count, sb.compared, sb.largest);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
